@@ rtl/pdw_pkg.sv @@
// Shared types and constants for the heading PID wheel drive block.
package pdw_pkg;

    localparam int SPEED_W    = 10;
    localparam int GAIN_W     = 12;
    localparam int UPPER_W    = 17;
    localparam int ERR_W      = 15;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int INTEG_W    = 24;
    localparam int SUM_W      = INTEG_W + 2;
    localparam int DRV_W      = 38;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    localparam logic [SPEED_W-1:0] SPEED_RST = 10'd1023;
    localparam logic [GAIN_W-1:0]  PROP_RST  = 12'd2000;
    localparam logic [GAIN_W-1:0]  INTEG_RST = 12'd100;
    localparam logic [GAIN_W-1:0]  DERIV_RST = 12'd750;
    localparam logic [UPPER_W-1:0] UPPER_RST = 17'd40960;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPEED = 3'd0,
        REG_PROP  = 3'd1,
        REG_INTEG = 3'd2,
        REG_DERIV = 3'd3,
        REG_UPPER = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_limit;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [UPPER_W-1:0] integ_upper;
    } t_cfg;

    typedef struct packed {
        logic                    advance;
        logic                    tick_due;
        logic signed [ERR_W-1:0] heading_error;
    } t_step;

endpackage

@@ rtl/pdw_cfg_regs.sv @@
// Configuration register bank with plain write port.
module pdw_cfg_regs
    import pdw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit <= SPEED_RST;
            r_cfg.prop_gain   <= PROP_RST;
            r_cfg.integ_gain  <= INTEG_RST;
            r_cfg.deriv_gain  <= DERIV_RST;
            r_cfg.integ_upper <= UPPER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPEED: begin
                    r_cfg.speed_limit <= i_cfg_wdata[SPEED_W-1:0];
                end
                REG_PROP: begin
                    r_cfg.prop_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_INTEG: begin
                    r_cfg.integ_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_DERIV: begin
                    r_cfg.deriv_gain <= i_cfg_wdata[GAIN_W-1:0];
                end
                REG_UPPER: begin
                    r_cfg.integ_upper <= i_cfg_wdata[UPPER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pdw_pid_core.sv @@
// PID datapath with integral, previous error and held wheel drive registers.
module pdw_pid_core
    import pdw_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_step              i_step,
    output logic [SPEED_W-1:0] o_left,
    output logic [SPEED_W-1:0] o_right
);

    localparam logic signed [SUM_W-1:0] INTEG_MIN =
        {{(SUM_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

    logic signed [INTEG_W-1:0]       r_integ;
    logic signed [ERR_W-1:0]         r_last;
    logic [SPEED_W-1:0]              r_left;
    logic [SPEED_W-1:0]              r_right;

    logic signed [INTEG_W-1:0]       n_integ;
    logic [SPEED_W-1:0]              n_left;
    logic [SPEED_W-1:0]              n_right;

    logic signed [SUM_W-1:0]         sum_raw;
    logic signed [SUM_W-1:0]         sum_upper;
    logic signed [SUM_W-1:0]         sum_clamp;
    logic signed [DIFF_W-1:0]        diff;
    logic signed [GAIN_W+ERR_W:0]    p_prod;
    logic signed [GAIN_W+INTEG_W:0]  i_prod;
    logic signed [GAIN_W+DIFF_W:0]   d_prod;
    logic signed [DRV_W-1:0]         drv;
    logic signed [DRV_W-1:0]         lim;
    logic signed [DRV_W-1:0]         drv_clamp;
    logic signed [DRV_W-1:0]         drv_abs;
    logic                            drv_neg;
    logic [SPEED_W-1:0]              mag;
    logic [SPEED_W-1:0]              reduced;

    always_comb begin
        sum_raw   = SUM_W'(r_integ) + SUM_W'(i_step.heading_error) + SUM_W'(r_last);
        sum_upper = $signed({{(SUM_W-UPPER_W){1'b0}}, i_cfg.integ_upper});
        if (sum_raw > sum_upper) begin
            sum_clamp = sum_upper;
        end else if (sum_raw < INTEG_MIN) begin
            sum_clamp = INTEG_MIN;
        end else begin
            sum_clamp = sum_raw;
        end
        n_integ = sum_clamp[INTEG_W-1:0];

        diff   = DIFF_W'(i_step.heading_error) - DIFF_W'(r_last);
        p_prod = $signed({1'b0, i_cfg.prop_gain}) * i_step.heading_error;
        i_prod = $signed({1'b0, i_cfg.integ_gain}) * n_integ;
        d_prod = $signed({1'b0, i_cfg.deriv_gain}) * diff;
        drv    = DRV_W'(p_prod) + DRV_W'(i_prod) + DRV_W'(d_prod);

        lim = $signed(DRV_W'(i_cfg.speed_limit) << FRAC_BITS);
        if (drv > lim) begin
            drv_clamp = lim;
        end else if (drv < -lim) begin
            drv_clamp = -lim;
        end else begin
            drv_clamp = drv;
        end

        drv_neg = drv_clamp[DRV_W-1];
        drv_abs = drv_neg ? -drv_clamp : drv_clamp;
        mag     = drv_abs[FRAC_BITS+SPEED_W-1:FRAC_BITS];
        reduced = i_cfg.speed_limit - mag;

        if (drv_neg) begin
            n_left  = reduced;
            n_right = i_cfg.speed_limit;
        end else begin
            n_left  = i_cfg.speed_limit;
            n_right = reduced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (i_step.advance && i_step.tick_due) begin
            r_integ <= n_integ;
            r_last  <= i_step.heading_error;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

@@ rtl/pid_heading_to_wheel_drive.sv @@
// Top level of the heading PID controller driving two wheel PWM values.
//
// Input stream: i_s_tdata carries the signed heading error (fraction bits set
// by FRAC_BITS), i_s_tuser flags a due control tick. Output stream: o_m_tdata
// carries the left and right wheel PWM compare values.
// Each accepted item yields exactly one output item. A due item updates the
// integral, the previous error and the held drives; an item that is not due
// repeats the held drives unchanged.
// The input register loads at the accepting edge; o_m_tvalid rises when the item
// moves on into the result register, which waits while the output stalls. Throughput:
// one item per cycle while the receiver does not stall, set by the single registered pass
// through the three gain multipliers.
// Configuration: write i_cfg_wdata to register i_cfg_addr (0 speed limit,
// 1 to 3 gains, 4 integral upper clamp) with i_cfg_we, only while idle.
// Reset (synchronous, active low) empties both registers, zeroes the integral,
// previous error and held drives, and restores the default gains and limits.
// When the receiver stalls, the output item holds and the input register keeps
// one further item; o_s_tready then falls until the output moves on.
module pid_heading_to_wheel_drive
    import pdw_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // [14:0] heading_error, [15] zero
    input  logic                  i_s_tuser,   // [0] tick_due
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // [9:0] left_drive, [19:10] right_drive
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                    w_cfg;
    t_step                   w_step;
    logic [SPEED_W-1:0]      w_left;
    logic [SPEED_W-1:0]      w_right;

    logic                    r_in_valid;
    logic signed [ERR_W-1:0] r_in_err;
    logic                    r_in_due;
    logic                    r_out_valid;
    logic                    advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_err <= $signed(i_s_tdata[ERR_W-1:0]);
            r_in_due <= i_s_tuser;
        end
    end

    assign w_step.advance       = advance;
    assign w_step.tick_due      = r_in_due;
    assign w_step.heading_error = r_in_err;

    pdw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pdw_pid_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .o_left  (w_left),
        .o_right (w_right)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-2*SPEED_W){1'b0}}, w_right, w_left};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_idle_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_due |=> $stable(o_m_tdata))
        else $error("drives changed on a tick that was not due");

    a_one_wheel_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_due |=>
            (w_left == $past(w_cfg.speed_limit)) || (w_right == $past(w_cfg.speed_limit)))
        else $error("neither wheel at speed limit after update");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("item taken while both registers held");

endmodule

@@ dv/tb_pid_heading_to_wheel_drive.sv @@
// Self-checking testbench for the heading PID wheel drive block: predicted drives vs DUT output.
`timescale 1ns / 100ps

module tb_pid_heading_to_wheel_drive;
    import pdw_pkg::*;

    localparam int FRAC_BITS   = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PI_Q        = 12868;
    localparam int HOLD_OFF    = 80;
    localparam int ERR_POS_MAX = (1 << (ERR_W - 1)) - 1;
    localparam int ERR_NEG_MAX = -(1 << (ERR_W - 1));
    localparam longint INTEG_FLOOR = -(longint'(1) << (INTEG_W - 1));

    typedef struct {
        logic [SPEED_W-1:0] left;
        logic [SPEED_W-1:0] right;
    } wheel_drive_t;

    class pid_drive_tracker;
        logic [SPEED_W-1:0]        speed;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [GAIN_W-1:0]         kd;
        logic [UPPER_W-1:0]        upper;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  prev_err;
        wheel_drive_t              held;
        wheel_drive_t              expected_drives[$];
        int n_errors, n_checked, n_due, n_repeat, n_floor, n_ceiling, n_clip;

        function new();
            speed    = SPEED_RST;
            kp       = PROP_RST;
            ki       = INTEG_RST;
            kd       = DERIV_RST;
            upper    = UPPER_RST;
            integ    = '0;
            prev_err = '0;
            held     = '{left: '0, right: '0};
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SPEED: speed = val[SPEED_W-1:0];
                REG_PROP:  kp    = val[GAIN_W-1:0];
                REG_INTEG: ki    = val[GAIN_W-1:0];
                REG_DERIV: kd    = val[GAIN_W-1:0];
                REG_UPPER: upper = val[UPPER_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_heading(logic signed [ERR_W-1:0] err, logic due);
            longint e, p, s, drv, lim, d;
            if (due) begin
                e = err;
                p = prev_err;
                s = longint'(integ) + e + p;
                if (s > longint'(upper)) begin
                    s = upper;
                    n_ceiling++;
                end
                if (s < INTEG_FLOOR) begin
                    s = INTEG_FLOOR;
                    n_floor++;
                end
                integ = INTEG_W'(s);
                drv = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - p);
                lim = longint'(speed) << FRAC_BITS;
                if (drv > lim || drv < -lim) n_clip++;
                if (drv > lim) drv = lim;
                if (drv < -lim) drv = -lim;
                if (drv >= 0) d = drv >>> FRAC_BITS;
                else d = -((-drv) >>> FRAC_BITS);
                if (d >= 0) begin
                    held.left  = speed;
                    held.right = SPEED_W'(longint'(speed) - d);
                end else begin
                    held.left  = SPEED_W'(longint'(speed) + d);
                    held.right = speed;
                end
                prev_err = DIFF_W'(e);
                n_due++;
            end else begin
                n_repeat++;
            end
            expected_drives.push_back(held);
        endfunction

        function void check_drive(logic [M_DATA_W-1:0] data);
            wheel_drive_t want;
            logic [SPEED_W-1:0] got_l, got_r;
            got_l = data[SPEED_W-1:0];
            got_r = data[2*SPEED_W-1:SPEED_W];
            if (expected_drives.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected drive item, left %0d right %0d", $time, got_l, got_r);
                return;
            end
            want = expected_drives.pop_front();
            n_checked++;
            if (got_l !== want.left) begin
                n_errors++;
                $display("%0t: left_drive expected %0d actual %0d", $time, want.left, got_l);
            end
            if (got_r !== want.right) begin
                n_errors++;
                $display("%0t: right_drive expected %0d actual %0d", $time, want.right, got_r);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata;   // [14:0] heading_error, [15] zero
    logic                  i_s_tuser;   // [0] tick_due
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_DATA_W-1:0]   o_m_tdata;   // [9:0] left_drive, [19:10] right_drive
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pid_drive_tracker sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int cycle_count;
    int items_sent;
    int n_configs;
    logic signed [ERR_W-1:0] walk_err;

    pid_heading_to_wheel_drive #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_pid_heading_to_wheel_drive: FAIL");
            $finish;
        end
    end

    // Result side: check each item, then stall at random or hold off on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) sb.check_drive(o_m_tdata);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [CFG_DATA_W-1:0] with_junk(int val, int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << width) - 1'b1;
        return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 0;
        if (r < 24) return (1 << GAIN_W) - 1;
        return $urandom_range((1 << GAIN_W) - 1);
    endfunction

    function automatic int pick_speed();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 25) return 1;
        if (r < 40) return (1 << SPEED_W) - 1;
        return $urandom_range((1 << SPEED_W) - 1, 1);
    endfunction

    function automatic int pick_upper();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 30) return (1 << UPPER_W) - 1;
        return $urandom_range((1 << UPPER_W) - 1);
    endfunction

    function automatic logic signed [ERR_W-1:0] pick_error(logic signed [ERR_W-1:0] prev);
        int r, v;
        r = $urandom_range(99);
        if (r < 40) v = int'($urandom_range(1024)) - 512;
        else if (r < 70) v = int'($urandom_range(2 * PI_Q)) - PI_Q;
        else if (r < 85) v = int'($urandom_range(ERR_POS_MAX - ERR_NEG_MAX)) + ERR_NEG_MAX;
        else begin
            v = int'(prev) + int'($urandom_range(400)) - 200;
            if (v > PI_Q) v = PI_Q;
            if (v < -PI_Q) v = -PI_Q;
        end
        return ERR_W'(v);
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Write all registers with junk above each width, then poke the unused indexes
    task automatic apply_config(int spd, int kp, int ki, int kd, int up);
        write_reg(REG_SPEED, with_junk(spd, SPEED_W));
        write_reg(REG_PROP,  with_junk(kp, GAIN_W));
        write_reg(REG_INTEG, with_junk(ki, GAIN_W));
        write_reg(REG_DERIV, with_junk(kd, GAIN_W));
        write_reg(REG_UPPER, with_junk(up, UPPER_W));
        for (int k = int'(REG_UPPER) + 1; k < (1 << CFG_ADDR_W); k++)
            write_reg(CFG_ADDR_W'(k), CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        n_configs++;
    endtask

    task automatic send_item(logic signed [ERR_W-1:0] err, logic due);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, err};
        i_s_tuser  <= due;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_heading(err, due);
        items_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(int n, int snd, int rcv, int hold_at, int pause_at);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        apply_config(pick_speed(), pick_gain(), pick_gain(), pick_gain(), pick_upper());
        for (int k = 0; k < n; k++) begin
            if (k == hold_at) hold_off_cycles = HOLD_OFF;
            if (k == pause_at) drain();
            walk_err = pick_error(walk_err);
            send_item(walk_err, $urandom_range(3) != 0);
        end
        drain();
    endtask

    // Drive the integral down to its floor with near-minimum errors
    task automatic run_windup(int n);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        apply_config((1 << SPEED_W) - 1, pick_gain(), $urandom_range(64, 1), pick_gain(),
                     pick_upper());
        for (int k = 0; k < n; k++)
            send_item(ERR_W'(ERR_NEG_MAX + int'($urandom_range(15))), $urandom_range(15) != 0);
        drain();
    endtask

    initial begin
        sb = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        cycle_count     = 0;
        items_sent      = 0;
        n_configs       = 0;
        walk_err        = '0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= REG_SPEED;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: held drives before any update, then extremes of the error
        send_item(ERR_W'($urandom), 1'b0);
        send_item('0, 1'b1);
        send_item(ERR_W'(ERR_POS_MAX), 1'b1);
        send_item(ERR_W'(ERR_POS_MAX), 1'b1);
        send_item(ERR_W'(ERR_NEG_MAX), 1'b1);
        send_item(ERR_W'(PI_Q), 1'b1);
        send_item(ERR_W'(-PI_Q), 1'b1);
        send_item(ERR_W'(1), 1'b1);
        send_item(ERR_W'(-1), 1'b1);
        send_item(ERR_W'(ERR_NEG_MAX), 1'b0);
        send_item('0, 1'b1);
        drain();

        // Zero speed limit with maximum gains and integral ceiling
        apply_config(0, (1 << GAIN_W) - 1, (1 << GAIN_W) - 1, (1 << GAIN_W) - 1,
                     (1 << UPPER_W) - 1);
        send_item(ERR_W'(PI_Q), 1'b1);
        send_item(ERR_W'(-PI_Q), 1'b1);
        send_item(ERR_W'(ERR_POS_MAX), 1'b0);
        send_item(ERR_W'(5), 1'b1);
        drain();

        // Unit speed and gain: truncation toward zero at one step either side
        apply_config(1, 1, 0, 0, 0);
        send_item(ERR_W'(1 << FRAC_BITS), 1'b1);
        send_item(ERR_W'((1 << FRAC_BITS) - 1), 1'b1);
        send_item(ERR_W'(1 - (1 << FRAC_BITS)), 1'b1);
        send_item(ERR_W'(-(1 << FRAC_BITS)), 1'b1);
        send_item(ERR_W'(ERR_NEG_MAX), 1'b1);
        send_item(ERR_W'(ERR_POS_MAX), 1'b1);
        drain();

        run_phase(65, 0, 0, -1, -1);
        run_phase(65, 69, 0, -1, -1);
        run_phase(65, 0, 69, 30, -1);
        run_phase(65, 13, 13, -1, 30);
        run_windup(290);

        drain();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d heading items over %0d register settings; %0d drives checked",
                 items_sent, n_configs, sb.n_checked);
        $display("%0d updates, %0d repeats; integral floor %0d, ceiling %0d, drive clipped %0d",
                 sb.n_due, sb.n_repeat, sb.n_floor, sb.n_ceiling, sb.n_clip);
        if (sb.n_errors == 0) begin
            $display("tb_pid_heading_to_wheel_drive: PASS");
        end else begin
            $display("tb_pid_heading_to_wheel_drive: FAIL");
        end
        $finish;
    end

endmodule
